/* rtl/core/assert_macros.svh */
// assertion macros for rtl files that check themselves; used by the top level
// needs signals clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock while out of reset
`define CFDC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked only once reset has been released for a full cycle
`define CFDC_ASSERT_RUN(label, prop, msg) \
	`CFDC_ASSERT(label, $past(arst_n) |-> (prop), msg)

`endif

/* rtl/core/cfdc_pkg.sv */
`timescale 1ns / 1ps
// types, widths and face table for the cube face direction to color block
// no dependencies
package cfdc_pkg;

	// component widths, all in units of 2/face size with the common scale removed
	localparam int EW    = 12;  // signed direction component
	localparam int MW    = 11;  // magnitude of a positive component
	localparam int SQW   = 22;  // one squared component
	localparam int SW    = 23;  // sum of squares
	localparam int RW    = 20;  // 510 * component
	localparam int RRW   = 40;  // (510 * component)^2
	localparam int XW    = 31;  // partial result * sum of squares
	localparam int YW    = 39;  // partial result^2 * sum of squares
	localparam int TW    = 42;  // trial product
	localparam int CW    = 8;   // color channel width

	localparam int NLANE  = 3;
	localparam int NFRONT = 3;
	localparam int NSRCH  = CW;
	localparam int NSTAGE = NFRONT + NSRCH;

	localparam logic [MW:0] ORIGIN_MAG = 12'd512;
	localparam logic [RW-1:0] SCALE_510 = 20'd510;

	// face codes
	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	// coefficient codes
	typedef logic [1:0] coef_t;
	localparam coef_t CP = 2'b01;
	localparam coef_t CN = 2'b11;
	localparam coef_t CZ = 2'b00;

	typedef struct packed {
		coef_t o;
		coef_t sx;
		coef_t sy;
	} axis_t;

	typedef axis_t [NLANE-1:0] face_axes_t;

	typedef struct packed {
		logic [9:0] column;
		logic [9:0] row;
		logic [2:0] face;
	} pixel_t;

	typedef struct packed {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
	} color_t;

	// one color channel under search
	typedef struct packed {
		logic           pos;
		logic [RRW-1:0] rr;
		logic [CW-1:0]  cur;
		logic [XW-1:0]  xs;
		logic [YW-1:0]  ys;
	} lane_t;

	typedef struct packed {
		logic [SW-1:0]          ssum;
		lane_t [NLANE-1:0]      lane;
	} srch_t;

	// origin, column step and row step per axis (index 0 x, 1 y, 2 z)
	function automatic face_axes_t face_axes(logic [2:0] face);
		face_axes_t r;
		r = '0;
		case (face)
			FACE_POS_X: begin
				r[0] = {CP, CZ, CZ}; r[1] = {CN, CZ, CP}; r[2] = {CP, CN, CZ};
			end
			FACE_NEG_X: begin
				r[0] = {CN, CZ, CZ}; r[1] = {CN, CZ, CP}; r[2] = {CN, CP, CZ};
			end
			FACE_POS_Y: begin
				r[0] = {CN, CP, CZ}; r[1] = {CP, CZ, CZ}; r[2] = {CP, CZ, CN};
			end
			FACE_NEG_Y: begin
				r[0] = {CN, CP, CZ}; r[1] = {CN, CZ, CZ}; r[2] = {CN, CZ, CP};
			end
			FACE_POS_Z: begin
				r[0] = {CN, CP, CZ}; r[1] = {CN, CZ, CP}; r[2] = {CP, CZ, CZ};
			end
			FACE_NEG_Z: begin
				r[0] = {CP, CN, CZ}; r[1] = {CN, CZ, CP}; r[2] = {CN, CZ, CZ};
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/cube_face_direction_color_top.sv */
`timescale 1ns / 1ps
// top level: pixel to color pipeline with per-stage flow control
// depends on cfdc_pkg, cfdc_front, cfdc_search, assert_macros.svh

// Takes one pixel (column, row, face) per clock while the output is not
// stalled and returns its red, green and blue, each the exact half-up
// rounding of 255 times the normalized x, z or y direction component, or 0
// where that component is not positive or the face code is 6 or 7. The pipe
// has three front stages (direction, squares, sum and targets) and one stage
// per result bit of the rounding search, the last of which is the output
// register. Each stage advances on its own, so empty stages fill in behind a
// stalled output and input keeps flowing until the pipe is full.
module cube_face_direction_color_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	input  cfdc_pkg::pixel_t  pixel,
	output logic              color_valid,
	input  logic              color_ready,
	output cfdc_pkg::color_t  color
);

	`include "assert_macros.svh"

	logic [cfdc_pkg::NSTAGE-1:0] vld;
	logic [cfdc_pkg::NSTAGE-1:0] en;
	cfdc_pkg::srch_t             srch;

	// a stage takes a new item when it is empty or its item moves on
	always_comb begin
		en[cfdc_pkg::NSTAGE-1] = !vld[cfdc_pkg::NSTAGE-1] || color_ready;
		for (int i = cfdc_pkg::NSTAGE - 2; i >= 0; i--) begin
			en[i] = !vld[i] || en[i+1];
		end
	end

	assign pixel_ready = en[0];
	assign color_valid = vld[cfdc_pkg::NSTAGE-1];

	cfdc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.en          (en[cfdc_pkg::NFRONT-1:0]),
		.vld         (vld[cfdc_pkg::NFRONT-1:0]),
		.srch        (srch)
	);

	cfdc_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.srch_in (srch),
		.vld_in  (vld[cfdc_pkg::NFRONT-1]),
		.en      (en[cfdc_pkg::NSTAGE-1:cfdc_pkg::NFRONT]),
		.vld     (vld[cfdc_pkg::NSTAGE-1:cfdc_pkg::NFRONT]),
		.color   (color)
	);

	// items in flight change only by transfers at the two ends
	`CFDC_ASSERT_RUN(a_occupancy, $countones(vld) == $past($countones(vld)) + ($past(pixel_valid && pixel_ready) ? 1 : 0) - ($past(color_valid && color_ready) ? 1 : 0), "pipeline lost or duplicated an item")

	// a stalled stage keeps its item
	`CFDC_ASSERT_RUN(a_stall_hold, ($past(vld & ~en) & ~vld) == '0, "stalled stage dropped its item")

	// any empty stage lets a new transfer in
	`CFDC_ASSERT(a_bubble_ready, !(&vld) |-> pixel_ready, "input blocked with an empty stage")

endmodule

/* rtl/core/cfdc_front.sv */
`timescale 1ns / 1ps
// front stages: direction components, squares, sum of squares and targets
// depends on cfdc_pkg
module cfdc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfdc_pkg::pixel_t                    pixel,
	input  logic                                pixel_valid,
	input  logic [cfdc_pkg::NFRONT-1:0]         en,
	output logic [cfdc_pkg::NFRONT-1:0]         vld,
	output cfdc_pkg::srch_t                     srch
);

	// signed coefficient times magnitude
	function automatic logic signed [cfdc_pkg::EW:0] scale(
		cfdc_pkg::coef_t c, logic [cfdc_pkg::MW:0] m);
		logic signed [cfdc_pkg::EW:0] v;
		v = $signed({1'b0, m});
		case (c)
			cfdc_pkg::CP: return v;
			cfdc_pkg::CN: return -v;
			default:      return '0;
		endcase
	endfunction

	cfdc_pkg::face_axes_t                  axes;
	logic signed [cfdc_pkg::EW:0]          comp_d [cfdc_pkg::NLANE];
	logic signed [cfdc_pkg::EW-1:0]        comp_s1 [cfdc_pkg::NLANE];
	logic signed [2*cfdc_pkg::EW-1:0]      sq_d [cfdc_pkg::NLANE];
	logic [cfdc_pkg::SQW-1:0]              sq_s2 [cfdc_pkg::NLANE];
	logic [cfdc_pkg::RW-1:0]               r_s2 [cfdc_pkg::NLANE];
	logic                                  pos_s2 [cfdc_pkg::NLANE];
	cfdc_pkg::srch_t                       srch_s3;

	// direction components
	always_comb begin
		axes = cfdc_pkg::face_axes(pixel.face);
		for (int k = 0; k < cfdc_pkg::NLANE; k++) begin
			comp_d[k] = scale(axes[k].o, cfdc_pkg::ORIGIN_MAG)
				+ scale(axes[k].sx, {2'b00, pixel.column})
				+ scale(axes[k].sy, {2'b00, pixel.row});
		end
	end

	// squares of the registered components
	always_comb begin
		for (int k = 0; k < cfdc_pkg::NLANE; k++) begin
			sq_d[k] = comp_s1[k] * comp_s1[k];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) vld[0] <= pixel_valid;
			if (en[1]) vld[1] <= vld[0];
			if (en[2]) vld[2] <= vld[1];
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		for (int k = 0; k < cfdc_pkg::NLANE; k++) begin
			if (en[0]) begin
				comp_s1[k] <= comp_d[k][cfdc_pkg::EW-1:0];
			end
			if (en[1]) begin
				sq_s2[k]  <= sq_d[k][cfdc_pkg::SQW-1:0];
				pos_s2[k] <= (comp_s1[k] > 0);
				r_s2[k]   <= (comp_s1[k] > 0)
					? cfdc_pkg::RW'(comp_s1[k][cfdc_pkg::MW-1:0]) * cfdc_pkg::SCALE_510
					: '0;
			end
			if (en[2]) begin
				srch_s3.lane[k].pos <= pos_s2[k];
				srch_s3.lane[k].rr  <= cfdc_pkg::RRW'(r_s2[k]) * cfdc_pkg::RRW'(r_s2[k]);
				srch_s3.lane[k].cur <= '0;
				srch_s3.lane[k].xs  <= '0;
				srch_s3.lane[k].ys  <= '0;
			end
		end
		if (en[2]) begin
			srch_s3.ssum <= cfdc_pkg::SW'(sq_s2[0]) + cfdc_pkg::SW'(sq_s2[1])
				+ cfdc_pkg::SW'(sq_s2[2]);
		end
	end

	assign srch = srch_s3;

endmodule

/* rtl/core/cfdc_search.sv */
`timescale 1ns / 1ps
// rounding search: one result bit per stage, most significant first
// depends on cfdc_pkg
module cfdc_search (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfdc_pkg::srch_t                  srch_in,
	input  logic                             vld_in,
	input  logic [cfdc_pkg::NSRCH-1:0]       en,
	output logic [cfdc_pkg::NSRCH-1:0]       vld,
	output cfdc_pkg::color_t                 color
);

	cfdc_pkg::srch_t srch_s [cfdc_pkg::NSRCH];

	for (genvar j = 0; j < cfdc_pkg::NSRCH; j++) begin : g_stage
		localparam int B  = 1 << (cfdc_pkg::NSRCH - 1 - j);
		localparam int M  = 2 * B - 1;

		cfdc_pkg::srch_t             prev;
		cfdc_pkg::srch_t             nxt;
		logic                        prev_vld;
		logic [cfdc_pkg::TW-1:0]     trial [cfdc_pkg::NLANE];

		if (j == 0) begin : g_first
			assign prev     = srch_in;
			assign prev_vld = vld_in;
		end else begin : g_next
			assign prev     = srch_s[j-1];
			assign prev_vld = vld[j-1];
		end

		// (2n-1)^2 * S for n = cur + B, built from cur*S and cur^2*S
		always_comb begin
			nxt = prev;
			for (int k = 0; k < cfdc_pkg::NLANE; k++) begin
				trial[k] = (cfdc_pkg::TW'(prev.lane[k].ys) << 2)
					+ cfdc_pkg::TW'(prev.lane[k].xs) * cfdc_pkg::TW'(4 * M)
					+ cfdc_pkg::TW'(prev.ssum) * cfdc_pkg::TW'(M * M);
				if (prev.lane[k].pos && (trial[k] <= cfdc_pkg::TW'(prev.lane[k].rr))) begin
					nxt.lane[k].cur = prev.lane[k].cur | cfdc_pkg::CW'(B);
					nxt.lane[k].xs  = prev.lane[k].xs
						+ cfdc_pkg::XW'(prev.ssum) * cfdc_pkg::XW'(B);
					nxt.lane[k].ys  = prev.lane[k].ys
						+ cfdc_pkg::YW'(prev.lane[k].xs) * cfdc_pkg::YW'(2 * B)
						+ cfdc_pkg::YW'(prev.ssum) * cfdc_pkg::YW'(B * B);
				end
			end
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[j] <= 1'b0;
			end else if (en[j]) begin
				vld[j] <= prev_vld;
			end
		end

		// stage data
		always_ff @(posedge clk) begin
			if (en[j]) begin
				srch_s[j] <= nxt;
			end
		end
	end

	// red from x, green from z, blue from y
	assign color.red   = srch_s[cfdc_pkg::NSRCH-1].lane[0].cur;
	assign color.green = srch_s[cfdc_pkg::NSRCH-1].lane[2].cur;
	assign color.blue  = srch_s[cfdc_pkg::NSRCH-1].lane[1].cur;

endmodule
